// ===== sv/tup5_pkg.sv =====
package tup5_pkg;

	localparam int NUM_REGS    = 8;
	localparam int CFG_AW      = $clog2(NUM_REGS);
	localparam int BYTE_W      = 8;
	localparam int RUN_W       = 7;
	localparam int IDX_W       = 5;
	localparam int OUT_DATA_W  = 40;  // 33 payload bits padded to whole bytes
	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] ALPHA_RESET [NUM_REGS] = '{
		32'h6463_6261, 32'h6867_6665, 32'h6C6B_6A69, 32'h706F_6E6D,
		32'h7473_7271, 32'h7877_7675, 32'h2C20_7A79, 32'h222D_3B2E
	};

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WORD = 2'd1,
		PH_ESC  = 2'd2,
		PH_RUN  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_TRIPLE = 2'd2,
		KIND_RUN    = 2'd3
	} kind_t;

	// one classified operation handed from front to back
	typedef struct packed {
		kind_t                 kind;
		logic [2*BYTE_W-1:0]   word;  // held byte in the upper half, current byte below
		logic                  fin;
	} op_t;

endpackage

// ===== sv/text_unpack_five_bit_rle_decoder_core.sv =====
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: packed_byte; tlast: final_byte
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: out_kind .. run_length; tlast: end_of_text
// cfg       in   cfg_wr_en                      cfg_addr: register index; cfg_wdata: value
//
// one byte per cycle while the queue is not full; the front classifies it in the
// cycle of its transfer and the result passes through the queue to the back output register
// a two-entry queue between front and back lets each side stall on its own
// reset clears phase, queue and output valid and reloads the default alphabet
// m_axis backpressure fills the queue; s_axis_tready falls only when it is full
module text_unpack_five_bit_rle_decoder_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tup5_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] packed_byte
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [1:0] out_kind, [9:2] char_first, [17:10] char_second, [25:18] char_third,
	// [32:26] run_length, [39:33] zero
	output logic [tup5_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tlast,
	input  logic                               cfg_wr_en,
	input  logic [tup5_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [31:0]                        cfg_wdata
);
	import tup5_pkg::*;

	logic fire;
	logic push;
	logic pop;
	logic full;
	logic empty;
	op_t  push_op;
	op_t  head_op;

	assign s_axis_tready = !full;
	assign fire          = s_axis_tvalid && !full;

	tup5_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (s_axis_tdata),
		.fin     (s_axis_tlast),
		.push    (push),
		.op      (push_op)
	);

	tup5_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.full    (full),
		.empty   (empty)
	);

	tup5_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.head_op   (head_op),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== sv/tup5_front.sv =====
module tup5_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [tup5_pkg::BYTE_W-1:0]   byte_in,
	input  logic                          fin,
	output logic                          push,
	output tup5_pkg::op_t                 op
);
	import tup5_pkg::*;

	phase_t              phase_q;
	phase_t              phase_next;
	logic [BYTE_W-1:0]   held_q;
	logic                hold_load;

	// next state
	always_comb begin
		phase_next = phase_q;
		hold_load  = 1'b0;
		if (fire) begin
			case (phase_q)
				PH_IDLE: begin
					if (byte_in[BYTE_W-1]) begin
						phase_next = PH_WORD;
						hold_load  = 1'b1;
					end else if (byte_in == '0) begin
						phase_next = PH_ESC;
					end
				end
				PH_WORD: phase_next = PH_IDLE;
				PH_ESC: begin
					if (byte_in[BYTE_W-1]) begin
						phase_next = PH_IDLE;
					end else begin
						phase_next = PH_RUN;
						hold_load  = 1'b1;
					end
				end
				PH_RUN: phase_next = PH_IDLE;
				default: phase_next = PH_IDLE;
			endcase
			// an unfinished sequence is dropped at end of text
			if (fin) begin
				phase_next = PH_IDLE;
			end
		end
	end

	// classified operation
	always_comb begin
		op.kind = KIND_NONE;
		op.word = {held_q, byte_in};
		op.fin  = fin;
		case (phase_q)
			PH_IDLE: begin
				op.word = {{BYTE_W{1'b0}}, byte_in};
				if (!byte_in[BYTE_W-1] && byte_in != '0) begin
					op.kind = KIND_CHAR;
				end
			end
			PH_WORD: op.kind = KIND_TRIPLE;
			PH_ESC: begin
				// quoted literal loses its top bit
				op.word = {{BYTE_W{1'b0}}, 1'b0, byte_in[BYTE_W-2:0]};
				if (byte_in[BYTE_W-1]) begin
					op.kind = KIND_CHAR;
				end
			end
			PH_RUN: op.kind = KIND_RUN;
			default: op.kind = KIND_NONE;
		endcase
		push = fire && (op.kind != KIND_NONE || fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else begin
			phase_q <= phase_next;
			if (hold_load) begin
				held_q <= byte_in;
			end
		end
	end

`ifndef SYNTHESIS
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fin |=> phase_q == PH_IDLE)
		else $error("phase not idle after end of text");

	a_empty_only_fin: assert property (@(posedge clk) disable iff (!arst_n)
		push && op.kind == KIND_NONE |-> fin)
		else $error("empty operation pushed without end of text");
`endif

endmodule

// ===== sv/tup5_queue.sv =====
module tup5_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tup5_pkg::op_t   push_op,
	input  logic            pop,
	output tup5_pkg::op_t   head_op,
	output logic            full,
	output logic            empty
);
	import tup5_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	op_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign head_op = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ===== sv/tup5_back.sv =====
module tup5_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tup5_pkg::CFG_AW-1:0]       cfg_addr,
	input  logic [31:0]                       cfg_wdata,
	input  tup5_pkg::op_t                     head_op,
	input  logic                              empty,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tup5_pkg::OUT_DATA_W-1:0]   out_data,
	output logic                              out_last
);
	import tup5_pkg::*;

	logic [NUM_REGS-1:0][31:0] alpha_q;
	logic                      valid_q;
	logic [OUT_DATA_W-1:0]     data_q;
	logic                      last_q;

	kind_t             kind;
	logic [BYTE_W-1:0] c1;
	logic [BYTE_W-1:0] c2;
	logic [BYTE_W-1:0] c3;
	logic [RUN_W-1:0]  run;

	function automatic logic [BYTE_W-1:0] alpha_entry(
		input logic [NUM_REGS-1:0][31:0] regs,
		input logic [IDX_W-1:0]          idx
	);
		logic [31:0] r;
		r = regs[idx[IDX_W-1:2]];
		return r[{idx[1:0], 3'b000} +: BYTE_W];
	endfunction

	assign pop = !empty && (!valid_q || out_ready);

	always_comb begin
		kind = head_op.kind;
		c1   = '0;
		c2   = '0;
		c3   = '0;
		run  = '0;
		case (kind)
			KIND_CHAR: c1 = head_op.word[BYTE_W-1:0];
			KIND_TRIPLE: begin
				c1 = alpha_entry(alpha_q, head_op.word[14:10]);
				c2 = alpha_entry(alpha_q, head_op.word[9:5]);
				c3 = alpha_entry(alpha_q, head_op.word[4:0]);
			end
			KIND_RUN: begin
				c1  = head_op.word[BYTE_W-1:0];
				run = head_op.word[BYTE_W +: RUN_W];
			end
			default: c1 = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				alpha_q[i] <= ALPHA_RESET[i];
			end
		end else if (cfg_wr_en) begin
			alpha_q[cfg_addr] <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {7'b0, run, c3, c2, c1, kind};
			last_q <= head_op.fin;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

`ifndef SYNTHESIS
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && data_q[1:0] == KIND_NONE |-> last_q)
		else $error("empty result without end of text");
`endif

endmodule
